[rtl/core/gpo_pkg.sv]
// Shared types, widths and constants of the gait phase oscillator.
package gpo_pkg;

    localparam int PHASE_W   = 32;
    localparam int TICK_W    = 30;
    localparam int STEPS_W   = 7;
    localparam int TS_W      = 63;
    localparam int SPEED_W   = 16;
    localparam int ACC_W     = 15;
    localparam int IV_W      = 33;
    localparam int CNT_W     = 6;
    localparam int AMP_W     = 14;

    localparam int MUL_A_W   = 44;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 6;

    localparam int DIV_N_W   = 78;
    localparam int DIV_D_W   = 50;
    localparam int DIV_R_W   = DIV_D_W + 1;
    localparam int DIV_Q_W   = 32;
    localparam int DIV_CNT_W = 7;

    localparam logic REG_TICK  = 1'b0;
    localparam logic REG_STEPS = 1'b1;

    localparam logic [TICK_W-1:0]  TICK_RESET  = 30'd50000000;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd9;
    localparam logic [STEPS_W-1:0] STEPS_MAX   = 7'd64;

    localparam logic [30:0]        HALF_PI_Q30  = 31'd1686629713;
    localparam logic [30:0]        Q30_ONE      = 31'h40000000;
    localparam logic [PHASE_W-1:0] OFFSET_TURN  = 32'd34178264;
    localparam logic [AMP_W-1:0]   AMP_MAX      = 14'd12288;
    localparam logic [15:0]        CAD_MIN      = 16'd15360;
    localparam logic [15:0]        CAD_MAX      = 16'd56320;
    localparam logic [MUL_A_W-1:0] CAD_DEN_UNIT = 44'd15360000000000;
    localparam logic [DIV_D_W-1:0] OUT_X_DIV    = 50'd26843545600;
    localparam logic [45:0]        OUT_X_RND    = 46'd13421772800;
    localparam logic [TS_W-1:0]    IV_MIN       = 63'd330000000;
    localparam logic [TS_W-1:0]    IV_MAX       = 63'd5000000000;

    typedef struct packed {
        logic                  start;
        logic [MUL_A_W-1:0]    a;
        logic [MUL_B_W-1:0]    b;
        logic [MUL_CNT_W-1:0]  cnt;
    } mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_N_W-1:0]    n;
        logic [DIV_D_W-1:0]    d;
        logic [DIV_CNT_W-1:0]  cnt;
    } div_req_t;

    function automatic logic [6:0] taylor_div(input logic [2:0] idx);
        case (idx)
            3'd0:    taylor_div = 7'd110;
            3'd1:    taylor_div = 7'd72;
            3'd2:    taylor_div = 7'd42;
            3'd3:    taylor_div = 7'd20;
            default: taylor_div = 7'd6;
        endcase
    endfunction

endpackage

[rtl/core/gpo_mul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module gpo_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gpo_pkg::mul_req_t             req,
    output logic [gpo_pkg::MUL_P_W-1:0]   prod,
    output logic                          done
);
    import gpo_pkg::*;

    logic [MUL_P_W-1:0]   acc_reg;
    logic [MUL_P_W-1:0]   sh_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                cnt_reg <= req.cnt;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            sh_reg  <= MUL_P_W'(req.a);
            b_reg   <= req.b;
        end else if (cnt_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + sh_reg;
            end
            sh_reg <= {sh_reg[MUL_P_W-2:0], 1'b0};
            b_reg  <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

[rtl/core/gpo_div.sv]
// Restoring divider that retires one quotient bit per cycle.
module gpo_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gpo_pkg::div_req_t             req,
    output logic [gpo_pkg::DIV_Q_W-1:0]   quot,
    output logic [gpo_pkg::DIV_R_W-1:0]   rem,
    output logic                          done
);
    import gpo_pkg::*;

    logic [DIV_N_W-1:0]   n_reg;
    logic [DIV_D_W-1:0]   d_reg;
    logic [DIV_R_W-1:0]   r_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DIV_R_W-1:0]   r_shift;
    logic                 fits;

    assign r_shift = {r_reg[DIV_R_W-2:0], n_reg[DIV_N_W-1]};
    assign fits    = r_shift >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                cnt_reg <= req.cnt;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            n_reg <= req.n;
            d_reg <= req.d;
            r_reg <= '0;
            q_reg <= '0;
        end else if (cnt_reg != '0) begin
            n_reg <= {n_reg[DIV_N_W-2:0], 1'b0};
            r_reg <= fits ? (r_shift - {1'b0, d_reg}) : r_shift;
            q_reg <= {q_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

[rtl/core/gait_phase_oscillator_core.sv]
// Top level of the gait phase oscillator: sequencer, state and result register.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | req_type, timestamp_ns, moving, speed_q8
//  m_      | out       | m_valid / m_ready    | accel_x, accel_y, accel_z, phase_out
//  cfg_    | in        | cfg_wr_en            | cfg_index, cfg_wr_data
//
// An active item passes through a chain of multiply and divide steps on the bit-serial
// multiplier and divider, which retire one bit per cycle; an idle tick goes straight to the result,
// and an idle step event runs only the step update. The sequencer returns to idle as the result is registered.
// Reset is synchronous and active low and returns the oscillator state to zero.
// A new item is taken only when the sequencer is idle; a finished result waits in the
// output register while the next item is being worked on.
module gait_phase_oscillator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [gpo_pkg::TS_W-1:0]              s_timestamp_ns,
    input  logic                                  s_moving,
    input  logic [gpo_pkg::SPEED_W-1:0]           s_speed_q8,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [gpo_pkg::ACC_W-1:0]      m_accel_x,
    output logic signed [gpo_pkg::ACC_W-1:0]      m_accel_y,
    output logic signed [gpo_pkg::ACC_W-1:0]      m_accel_z,
    output logic [gpo_pkg::PHASE_W-1:0]           m_phase_out,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_index,
    input  logic [gpo_pkg::TICK_W-1:0]            cfg_wr_data
);
    import gpo_pkg::*;

    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_IVMUL  = 19'h00002,
        ST_CADDIV = 19'h00004,
        ST_CADMUL = 19'h00008,
        ST_DENMUL = 19'h00010,
        ST_PHDIV  = 19'h00020,
        ST_STEP   = 19'h00040,
        ST_KDIV   = 19'h00080,
        ST_TGTDIV = 19'h00100,
        ST_CORDIV = 19'h00200,
        ST_AMPDIV = 19'h00400,
        ST_XMUL   = 19'h00800,
        ST_X2MUL  = 19'h01000,
        ST_TMUL   = 19'h02000,
        ST_TDIV   = 19'h04000,
        ST_SMUL   = 19'h08000,
        ST_PMUL   = 19'h10000,
        ST_ODIV   = 19'h20000,
        ST_DONE   = 19'h40000
    } state_t;

    state_t               state_reg, state_next;
    logic                 issued_reg, issued_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [STEPS_W-1:0]   steps_cfg_reg, steps_cfg_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [IV_W-1:0]      interval_reg, interval_next;
    logic [TS_W-1:0]      last_reg, last_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic [TS_W-1:0]      ts_reg, ts_next;
    logic                 active_reg, active_next;
    logic [SPEED_W-1:0]   speed_reg, speed_next;
    logic [STEPS_W-1:0]   steps_reg, steps_next;
    logic [DIV_D_W-1:0]   den_reg, den_next;
    logic [45:0]          num_reg, num_next;
    logic [15:0]          cad_reg, cad_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [33:0]          cnum_reg, cnum_next;
    logic                 cneg_reg, cneg_next;
    logic [AMP_W-1:0]     amp_reg, amp_next;
    logic [1:0]           sel_reg, sel_next;
    logic [2:0]           ti_reg, ti_next;
    logic [30:0]          x_reg, x_next;
    logic [31:0]          x2_reg, x2_next;
    logic [30:0]          t_reg, t_next;
    logic [30:0]          s_reg, s_next;
    logic                 neg_reg, neg_next;
    logic [ACC_W-1:0]     ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [ACC_W-1:0]     m_ax_reg, m_ax_next, m_ay_reg, m_ay_next, m_az_reg, m_az_next;
    logic [PHASE_W-1:0]   m_phase_reg, m_phase_next;

    mul_req_t             mul_req;
    div_req_t             div_req;
    logic [MUL_P_W-1:0]   mul_p;
    logic                 mul_done;
    logic [DIV_Q_W-1:0]   div_q;
    logic [DIV_R_W-1:0]   div_r;
    logic                 div_done;
    logic                 op_done;

    logic [STEPS_W-1:0]   steps_eff;
    logic [20:0]          cad_base;
    logic [27:0]          cad_raw;
    logic [21:0]          amp_raw;
    logic [TS_W-1:0]      iv;
    logic                 iv_ok;
    logic [34:0]          iv_mix;
    logic [STEPS_W-1:0]   kp1;
    logic [PHASE_W-1:0]   d_err;
    logic [PHASE_W-1:0]   ang;
    logic [30:0]          f_ang;
    logic [45:0]          xsum;
    logic [46:0]          rnd_y, rnd_z;
    logic [ACC_W-1:0]     mag_y, mag_z, mag_x;

    gpo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .prod    (mul_p),
        .done    (mul_done)
    );

    gpo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .quot    (div_q),
        .rem     (div_r),
        .done    (div_done)
    );

    assign op_done = issued_reg & (mul_done | div_done);

    assign steps_eff = (steps_cfg_reg == '0) ? STEPS_W'(1) :
                       (steps_cfg_reg > STEPS_MAX) ? STEPS_MAX : steps_cfg_reg;
    assign cad_base  = 21'd15360 + 21'(speed_reg) * 21'd30;
    assign cad_raw   = 28'(cad_base) * 28'd115;
    assign amp_raw   = 22'(speed_reg) * 22'd56 + 22'd22533;
    assign iv        = ts_reg - last_reg;
    assign iv_ok     = (last_reg != '0) && (ts_reg > last_reg) && (iv > IV_MIN) && (iv < IV_MAX);
    assign iv_mix    = 35'(interval_reg) + 35'({interval_reg, 1'b0}) + 35'(iv[IV_W-1:0]);
    assign kp1       = STEPS_W'(k_reg) + STEPS_W'(1);
    assign d_err     = div_q - phase_reg;
    assign xsum      = 46'({mul_p[43:0], 1'b0}) + 46'(mul_p[43:0]) + OUT_X_RND;
    assign rnd_y     = 47'(mul_p[43:0]) + 47'h0_8000_0000;
    assign rnd_z     = 47'(mul_p[43:0]) + 47'h0_2000_0000;
    assign mag_y     = rnd_y[46:32];
    assign mag_z     = rnd_z[44:30];
    assign mag_x     = div_q[ACC_W-1:0];

    always_comb begin
        case (sel_reg)
            2'd0:    ang = phase_reg - OFFSET_TURN;
            2'd1:    ang = phase_reg + OFFSET_TURN;
            default: ang = phase_reg;
        endcase
        f_ang = ang[30] ? (Q30_ONE - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
    end

    always_comb begin
        mul_req = '0;
        div_req = '0;
        case (state_reg)
            ST_IVMUL: begin
                mul_req.a   = MUL_A_W'(interval_reg);
                mul_req.b   = MUL_B_W'(steps_reg);
                mul_req.cnt = MUL_CNT_W'(STEPS_W);
            end
            ST_CADMUL: begin
                mul_req.a   = MUL_A_W'(tick_reg);
                mul_req.b   = MUL_B_W'(cad_reg);
                mul_req.cnt = MUL_CNT_W'(16);
            end
            ST_DENMUL: begin
                mul_req.a   = CAD_DEN_UNIT;
                mul_req.b   = MUL_B_W'(steps_reg);
                mul_req.cnt = MUL_CNT_W'(STEPS_W);
            end
            ST_XMUL: begin
                mul_req.a   = MUL_A_W'(HALF_PI_Q30);
                mul_req.b   = MUL_B_W'(f_ang);
                mul_req.cnt = MUL_CNT_W'(31);
            end
            ST_X2MUL: begin
                mul_req.a   = MUL_A_W'(x_reg);
                mul_req.b   = MUL_B_W'(x_reg);
                mul_req.cnt = MUL_CNT_W'(31);
            end
            ST_TMUL: begin
                mul_req.a   = MUL_A_W'(x2_reg);
                mul_req.b   = MUL_B_W'(t_reg);
                mul_req.cnt = MUL_CNT_W'(31);
            end
            ST_SMUL: begin
                mul_req.a   = MUL_A_W'(x_reg);
                mul_req.b   = MUL_B_W'(t_reg);
                mul_req.cnt = MUL_CNT_W'(31);
            end
            ST_PMUL: begin
                mul_req.a   = MUL_A_W'(s_reg);
                mul_req.b   = MUL_B_W'(amp_reg);
                mul_req.cnt = MUL_CNT_W'(AMP_W);
            end
            ST_CADDIV: begin
                div_req.n   = DIV_N_W'(cad_raw) << (DIV_N_W - 28);
                div_req.d   = DIV_D_W'(100);
                div_req.cnt = DIV_CNT_W'(28);
            end
            ST_PHDIV: begin
                div_req.d = den_reg;
                if (interval_reg != '0) begin
                    div_req.n   = DIV_N_W'(tick_reg) << (DIV_N_W - TICK_W);
                    div_req.cnt = DIV_CNT_W'(TICK_W + PHASE_W);
                end else begin
                    div_req.n   = DIV_N_W'(num_reg) << (DIV_N_W - 46);
                    div_req.cnt = DIV_CNT_W'(46 + PHASE_W);
                end
            end
            ST_KDIV: begin
                div_req.n   = DIV_N_W'(count_reg) << (DIV_N_W - CNT_W);
                div_req.d   = DIV_D_W'(steps_reg);
                div_req.cnt = DIV_CNT_W'(CNT_W);
            end
            ST_TGTDIV: begin
                div_req.n   = DIV_N_W'(kp1) << (DIV_N_W - STEPS_W);
                div_req.d   = DIV_D_W'(steps_reg);
                div_req.cnt = DIV_CNT_W'(STEPS_W + PHASE_W);
            end
            ST_CORDIV: begin
                div_req.n   = DIV_N_W'(cnum_reg) << (DIV_N_W - 34);
                div_req.d   = DIV_D_W'(50);
                div_req.cnt = DIV_CNT_W'(34);
            end
            ST_AMPDIV: begin
                div_req.n   = DIV_N_W'(amp_raw) << (DIV_N_W - 22);
                div_req.d   = DIV_D_W'(10);
                div_req.cnt = DIV_CNT_W'(22);
            end
            ST_TDIV: begin
                div_req.n   = DIV_N_W'(mul_p[61:30]) << (DIV_N_W - 32);
                div_req.d   = DIV_D_W'(taylor_div(ti_reg));
                div_req.cnt = DIV_CNT_W'(32);
            end
            ST_ODIV: begin
                div_req.n   = DIV_N_W'(xsum) << (DIV_N_W - 46);
                div_req.d   = OUT_X_DIV;
                div_req.cnt = DIV_CNT_W'(46);
            end
            default: begin
                mul_req = '0;
                div_req = '0;
            end
        endcase
        mul_req.start = !issued_reg && (state_reg == ST_IVMUL || state_reg == ST_CADMUL ||
                        state_reg == ST_DENMUL || state_reg == ST_XMUL ||
                        state_reg == ST_X2MUL || state_reg == ST_TMUL ||
                        state_reg == ST_SMUL || state_reg == ST_PMUL);
        div_req.start = !issued_reg && (state_reg == ST_CADDIV || state_reg == ST_PHDIV ||
                        state_reg == ST_KDIV || state_reg == ST_TGTDIV ||
                        state_reg == ST_CORDIV || state_reg == ST_AMPDIV ||
                        state_reg == ST_TDIV || state_reg == ST_ODIV);
    end

    always_comb begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        m_valid_next   = m_valid_reg;
        tick_next      = tick_reg;
        steps_cfg_next = steps_cfg_reg;
        phase_next     = phase_reg;
        interval_next  = interval_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        ts_next        = ts_reg;
        active_next    = active_reg;
        speed_next     = speed_reg;
        steps_next     = steps_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        cad_next       = cad_reg;
        k_next         = k_reg;
        cnum_next      = cnum_reg;
        cneg_next      = cneg_reg;
        amp_next       = amp_reg;
        sel_next       = sel_reg;
        ti_next        = ti_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        neg_next       = neg_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        m_ax_next      = m_ax_reg;
        m_ay_next      = m_ay_reg;
        m_az_next      = m_az_reg;
        m_phase_next   = m_phase_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_TICK:  tick_next      = cfg_wr_data;
                REG_STEPS: steps_cfg_next = cfg_wr_data[STEPS_W-1:0];
                default:   tick_next      = tick_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (mul_req.start || div_req.start) begin
            issued_next = 1'b1;
        end
        if (op_done) begin
            issued_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ts_next     = s_timestamp_ns;
                    speed_next  = s_speed_q8;
                    active_next = s_moving && (s_speed_q8 > SPEED_W'(12));
                    steps_next  = steps_eff;
                    sel_next    = 2'd0;
                    ax_next     = '0;
                    ay_next     = '0;
                    az_next     = '0;
                    if (s_req_type) begin
                        state_next = ST_STEP;
                    end else if (!(s_moving && (s_speed_q8 > SPEED_W'(12)))) begin
                        state_next = ST_DONE;
                    end else if (interval_reg != '0) begin
                        state_next = ST_IVMUL;
                    end else begin
                        state_next = ST_CADDIV;
                    end
                end
            end
            ST_IVMUL: begin
                if (op_done) begin
                    den_next   = mul_p[DIV_D_W-1:0];
                    state_next = ST_PHDIV;
                end
            end
            ST_CADDIV: begin
                if (op_done) begin
                    if (div_q < 32'(CAD_MIN)) begin
                        cad_next = CAD_MIN;
                    end else if (div_q > 32'(CAD_MAX)) begin
                        cad_next = CAD_MAX;
                    end else begin
                        cad_next = div_q[15:0];
                    end
                    state_next = ST_CADMUL;
                end
            end
            ST_CADMUL: begin
                if (op_done) begin
                    num_next   = mul_p[45:0];
                    state_next = ST_DENMUL;
                end
            end
            ST_DENMUL: begin
                if (op_done) begin
                    den_next   = mul_p[DIV_D_W-1:0];
                    state_next = ST_PHDIV;
                end
            end
            ST_PHDIV: begin
                if (op_done) begin
                    phase_next = phase_reg + div_q;
                    state_next = ST_AMPDIV;
                end
            end
            ST_STEP: begin
                if (iv_ok) begin
                    interval_next = (interval_reg == '0) ? iv[IV_W-1:0] : iv_mix[34:2];
                end
                last_next  = ts_reg;
                state_next = ST_KDIV;
            end
            ST_KDIV: begin
                if (op_done) begin
                    k_next     = div_r[CNT_W-1:0];
                    state_next = ST_TGTDIV;
                end
            end
            ST_TGTDIV: begin
                if (op_done) begin
                    cneg_next = d_err[PHASE_W-1];
                    if (d_err[PHASE_W-1]) begin
                        cnum_next = 34'(33'h1_0000_0000 - 33'(d_err)) + 34'd25;
                    end else begin
                        cnum_next = 34'(d_err) + 34'd25;
                    end
                    count_next = (kp1 == steps_reg) ? '0 : kp1[CNT_W-1:0];
                    state_next = ST_CORDIV;
                end
            end
            ST_CORDIV: begin
                if (op_done) begin
                    phase_next = cneg_reg ? (phase_reg - div_q) : (phase_reg + div_q);
                    state_next = active_reg ? ST_AMPDIV : ST_DONE;
                end
            end
            ST_AMPDIV: begin
                if (op_done) begin
                    amp_next   = (div_q > 32'(AMP_MAX)) ? AMP_MAX : div_q[AMP_W-1:0];
                    sel_next   = 2'd0;
                    state_next = ST_XMUL;
                end
            end
            ST_XMUL: begin
                if (op_done) begin
                    x_next     = mul_p[60:30];
                    neg_next   = ang[31];
                    state_next = ST_X2MUL;
                end
            end
            ST_X2MUL: begin
                if (op_done) begin
                    x2_next    = mul_p[61:30];
                    t_next     = Q30_ONE;
                    ti_next    = 3'd0;
                    state_next = ST_TMUL;
                end
            end
            ST_TMUL: begin
                if (op_done) begin
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV: begin
                if (op_done) begin
                    t_next = Q30_ONE - div_q[30:0];
                    if (ti_reg == 3'd4) begin
                        state_next = ST_SMUL;
                    end else begin
                        ti_next    = ti_reg + 3'd1;
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_SMUL: begin
                if (op_done) begin
                    s_next     = mul_p[60:30];
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL: begin
                if (op_done) begin
                    case (sel_reg)
                        2'd0: begin
                            state_next = ST_ODIV;
                        end
                        2'd1: begin
                            ay_next    = neg_reg ? (~mag_y + ACC_W'(1)) : mag_y;
                            sel_next   = 2'd2;
                            state_next = ST_XMUL;
                        end
                        default: begin
                            az_next    = neg_reg ? (~mag_z + ACC_W'(1)) : mag_z;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ODIV: begin
                if (op_done) begin
                    ax_next    = neg_reg ? (~mag_x + ACC_W'(1)) : mag_x;
                    sel_next   = 2'd1;
                    state_next = ST_XMUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_ax_next    = ax_reg;
                    m_ay_next    = ay_reg;
                    m_az_next    = az_reg;
                    m_phase_next = phase_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            tick_reg      <= TICK_RESET;
            steps_cfg_reg <= STEPS_RESET;
            phase_reg     <= '0;
            interval_reg  <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            m_valid_reg   <= m_valid_next;
            tick_reg      <= tick_next;
            steps_cfg_reg <= steps_cfg_next;
            phase_reg     <= phase_next;
            interval_reg  <= interval_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ts_reg      <= ts_next;
        active_reg  <= active_next;
        speed_reg   <= speed_next;
        steps_reg   <= steps_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        cad_reg     <= cad_next;
        k_reg       <= k_next;
        cnum_reg    <= cnum_next;
        cneg_reg    <= cneg_next;
        amp_reg     <= amp_next;
        sel_reg     <= sel_next;
        ti_reg      <= ti_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        t_reg       <= t_next;
        s_reg       <= s_next;
        neg_reg     <= neg_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        az_reg      <= az_next;
        m_ax_reg    <= m_ax_next;
        m_ay_reg    <= m_ay_next;
        m_az_reg    <= m_az_next;
        m_phase_reg <= m_phase_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_accel_x   = m_ax_reg;
    assign m_accel_y   = m_ay_reg;
    assign m_accel_z   = m_az_reg;
    assign m_phase_out = m_phase_reg;

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer stayed idle after an input transfer");

    a_idle_no_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !issued_reg)
        else $error("arithmetic unit still running while idle");

    a_amp_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PMUL) |-> (amp_reg <= AMP_MAX))
        else $error("amplitude above its clamp");

    a_accel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_accel_z >= -15'sd12288 && m_accel_z <= 15'sd12288))
        else $error("vertical acceleration outside its range");

endmodule
